FILE: design/lfbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfbp_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 32;
    localparam int WIDTH_W = 6;
    localparam int PEND_W  = 7;
    localparam int CNT_W   = 3;

    // command codes
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_ALIGN  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [VALUE_W-1:0] field_value;
        logic [WIDTH_W-1:0] field_width;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_byte;
    } result_t;

endpackage

`default_nettype wire

FILE: design/lsb_first_bit_packer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                    Payload
// item      in   item_valid / item_stall      item   (cmd, field_value, field_width)
// result    out  result_valid / result_stall  result (out_byte, last_byte)
//
// An item is merged with the pending bits in the cycle of its transfer; its
// completed bytes (0..4) land in the result register, which sends one per cycle while result_stall is low.
// A new item waits while more than one byte of the previous one is left; the
// next item is taken while the last byte of the previous one goes out.
// Reset clears the pending bits and empties the result register.
// A stalled result holds its byte; item_stall rises while more than one byte waits, or one waits stalled.
module lsb_first_bit_packer #(
    parameter int MAX_FIELD_WIDTH = 32
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                item_valid,
    output logic               item_stall,
    input  wire lfbp_pkg::item_t item,
    output logic               result_valid,
    input  wire                result_stall,
    output lfbp_pkg::result_t  result
);
    import lfbp_pkg::*;

    // bytes one item can complete, given up to 7 pending bits
    localparam int MAX_BYTES = (PEND_W + MAX_FIELD_WIDTH) / BYTE_W;
    localparam int NB_W      = $clog2(MAX_BYTES + 1);

    logic                    busy;
    logic                    load;
    logic [MAX_BYTES*8-1:0]  bytes;
    logic [NB_W-1:0]         nbytes;

    assign item_stall = busy;
    assign load       = item_valid && !busy;   // item transfer

    lfbp_pack #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH),
        .MAX_BYTES       (MAX_BYTES),
        .NB_W            (NB_W)
    ) u_pack (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .item   (item),
        .bytes  (bytes),
        .nbytes (nbytes)
    );

    lfbp_obuf #(
        .MAX_BYTES (MAX_BYTES),
        .NB_W      (NB_W)
    ) u_obuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .bytes        (bytes),
        .nbytes       (nbytes),
        .busy         (busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: design/lfbp_pack.sv
`timescale 1ns / 1ps
`default_nettype none

// Holds the pending partial byte and merges one item into it per transfer.
module lfbp_pack #(
    parameter int MAX_FIELD_WIDTH = 32,
    parameter int MAX_BYTES       = 4,
    parameter int NB_W            = 3
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    load,
    input  wire lfbp_pkg::item_t   item,
    output logic [MAX_BYTES*8-1:0] bytes,
    output logic [NB_W-1:0]        nbytes
);
    import lfbp_pkg::*;

    localparam int ACC_W = PEND_W + MAX_FIELD_WIDTH;
    localparam int BUF_W = MAX_BYTES * BYTE_W;

    logic [PEND_W-1:0]  pend_reg,  pend_next;
    logic [CNT_W-1:0]   pcnt_reg,  pcnt_next;
    logic [WIDTH_W-1:0] w;
    logic [VALUE_W:0]   mask;
    logic [VALUE_W-1:0] value_m;
    logic [ACC_W-1:0]   acc;
    logic [ACC_W-1:0]   rest;
    logic [WIDTH_W-1:0] total;
    logic [NB_W-1:0]    nb_app;

    always_comb
    begin
        // saturate width, then keep only the requested low bits
        w = (item.field_width > WIDTH_W'(MAX_FIELD_WIDTH)) ?
            WIDTH_W'(MAX_FIELD_WIDTH) : item.field_width;
        mask    = ~({(VALUE_W + 1){1'b1}} << w);
        value_m = item.field_value & mask[VALUE_W-1:0];
        acc     = ACC_W'(pend_reg) | (ACC_W'(value_m[MAX_FIELD_WIDTH-1:0]) << pcnt_reg);
        total   = WIDTH_W'(pcnt_reg) + w;
        nb_app  = NB_W'(total >> 3);
        rest    = acc >> {nb_app, 3'b000};

        if (item.cmd == CMD_ALIGN)
        begin
            bytes     = BUF_W'(pend_reg);
            nbytes    = (pcnt_reg != '0) ? NB_W'(1) : '0;
            pend_next = '0;
            pcnt_next = '0;
        end
        else
        begin
            bytes     = BUF_W'(acc);
            nbytes    = nb_app;
            pend_next = rest[PEND_W-1:0];
            pcnt_next = total[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            pcnt_reg <= '0;
        end
        else if (load)
        begin
            pend_reg <= pend_next;
            pcnt_reg <= pcnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/lfbp_obuf.sv
`timescale 1ns / 1ps
`default_nettype none

// Result register: shifts out completed bytes, one per output transfer.
module lfbp_obuf #(
    parameter int MAX_BYTES = 4,
    parameter int NB_W      = 3
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    load,
    input  wire [MAX_BYTES*8-1:0]  bytes,
    input  wire [NB_W-1:0]         nbytes,
    output logic                   busy,
    output logic                   result_valid,
    input  wire                    result_stall,
    output lfbp_pkg::result_t      result
);
    import lfbp_pkg::*;

    localparam int BUF_W = MAX_BYTES * BYTE_W;

    logic [BUF_W-1:0] data_reg;
    logic [NB_W-1:0]  cnt_reg;
    logic             pop;

    assign result_valid     = (cnt_reg != '0);
    assign pop              = result_valid && !result_stall;
    assign result.out_byte  = data_reg[BYTE_W-1:0];
    assign result.last_byte = (cnt_reg == NB_W'(1));
    // a new item may load only if the buffer is empty or drains in this cycle
    assign busy = (cnt_reg > NB_W'(1)) || ((cnt_reg == NB_W'(1)) && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= nbytes;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - NB_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= bytes;
        end
        else if (pop)
        begin
            data_reg <= data_reg >> BYTE_W;
        end
    end

endmodule

`default_nettype wire

FILE: dv/tb_lsb_first_bit_packer.sv
`timescale 1ns / 1ps

// Testbench for lsb_first_bit_packer.
//
// A directed table runs first, then about 450 random items. Each accepted item
// goes through a local model of the packer, and the bytes it must produce are
// queued. Every byte transfer on the result side is checked against the head
// of that queue.
module tb_lsb_first_bit_packer;

    import lfbp_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int MAX_W          = 32;
    localparam int RAND_ITEMS_A   = 150;
    localparam int HOLD_ITEMS     = 12;
    localparam int RAND_ITEMS_B   = 100;
    localparam int RAND_ITEMS_C   = 190;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TIMEOUT_CYCLES = 200000;

    // Marks a table row whose bytes come from the model instead of the table.
    localparam logic [2:0] PRED = 3'd7;

    typedef enum logic [1:0] {RX_RANDOM, RX_FREE, RX_HOLD} rx_mode_t;

    // One row of the directed table. For typed rows, byte i of the expected
    // output sits in bytes[8*i +: 8]. The final byte carries last_byte.
    typedef struct packed {
        item_t      it;
        logic [2:0] n_typed;
        logic [31:0] bytes;
    } row_t;

    // The rows start right after reset. Pending bits carry from one row to the next.
    localparam row_t DIR_ROWS [24] = '{
        '{'{CMD_ALIGN,  32'h0000_0000, 6'd0 }, 3'd0, 32'h0000_0000}, // align, nothing pending
        '{'{CMD_APPEND, 32'hFFFF_FFFF, 6'd0 }, 3'd0, 32'h0000_0000}, // zero width
        '{'{CMD_APPEND, 32'h0000_01A5, 6'd8 }, 3'd1, 32'h0000_00A5}, // bit 8 dropped
        '{'{CMD_APPEND, 32'hDEAD_BEEF, 6'd32}, 3'd4, 32'hDEAD_BEEF},
        '{'{CMD_APPEND, 32'h1234_5678, 6'd63}, 3'd4, 32'h1234_5678}, // width clamps to 32
        '{'{CMD_APPEND, 32'hFFFF_FFFF, 6'd33}, 3'd4, 32'hFFFF_FFFF},
        '{'{CMD_APPEND, 32'hFFFF_FFFD, 6'd3 }, 3'd0, 32'h0000_0000}, // leaves 3'b101
        '{'{CMD_ALIGN,  32'hFFFF_FFFF, 6'd63}, 3'd1, 32'h0000_0005}, // operands ignored
        '{'{CMD_APPEND, 32'h0000_0001, 6'd1 }, 3'd0, 32'h0000_0000},
        '{'{CMD_APPEND, 32'hFFFF_FFFF, 6'd32}, PRED, 32'h0000_0000}, // 33 bits total
        '{'{CMD_APPEND, 32'h0000_0000, 6'd7 }, PRED, 32'h0000_0000},
        '{'{CMD_APPEND, 32'h0000_007F, 6'd7 }, 3'd0, 32'h0000_0000}, // 7 pending, max
        '{'{CMD_APPEND, 32'h0000_0000, 6'd1 }, 3'd1, 32'h0000_007F},
        '{'{CMD_APPEND, 32'h0000_0055, 6'd7 }, 3'd0, 32'h0000_0000},
        '{'{CMD_ALIGN,  32'h0000_0000, 6'd0 }, 3'd1, 32'h0000_0055},
        '{'{CMD_APPEND, 32'h0000_0000, 6'd32}, 3'd4, 32'h0000_0000},
        '{'{CMD_APPEND, 32'h7FFF_FFFF, 6'd31}, 3'd3, 32'h00FF_FFFF},
        '{'{CMD_APPEND, 32'h8000_0001, 6'd32}, PRED, 32'h0000_0000}, // 39 bits total
        '{'{CMD_APPEND, 32'hFFFF_FFFF, 6'd0 }, 3'd0, 32'h0000_0000}, // zero width, bits pending
        '{'{CMD_ALIGN,  32'h0000_0000, 6'd0 }, PRED, 32'h0000_0000},
        '{'{CMD_ALIGN,  32'hFFFF_FFFF, 6'd32}, 3'd0, 32'h0000_0000}, // back to back align
        '{'{CMD_APPEND, 32'hAAAA_AAAA, 6'd62}, 3'd4, 32'hAAAA_AAAA},
        '{'{CMD_APPEND, 32'h0000_0015, 6'd5 }, 3'd0, 32'h0000_0000},
        '{'{CMD_ALIGN,  32'h0000_0000, 6'd0 }, 3'd1, 32'h0000_0015}
    };

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    // Model state: the bits waiting to fill a byte, earliest in bit 0.
    logic [6:0] pk_bits;
    logic [2:0] pk_cnt;

    result_t  pred_q[$];     // bytes that the current item produces
    result_t  want_bytes[$]; // bytes still owed by the block, oldest first

    rx_mode_t rx_mode = RX_RANDOM;
    bit       tx_gaps;

    int unsigned n_errors;
    int unsigned n_items;
    int unsigned n_aligns;
    int unsigned n_zero_w;
    int unsigned n_big_w;
    int unsigned n_bytes;
    int unsigned n_in_stalls;

    lsb_first_bit_packer #(
        .MAX_FIELD_WIDTH (MAX_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Model of the packer. It fills pred_q with the bytes the item completes
    // and updates the pending bits.
    function automatic void pack_item(input item_t it);
        logic [39:0] acc;
        int unsigned w;
        int unsigned total;
        int unsigned nbytes;
        result_t     b;
        pred_q.delete();
        if (it.cmd == CMD_ALIGN)
        begin
            // An align with nothing pending changes nothing.
            if (pk_cnt != 0)
            begin
                b.out_byte  = {1'b0, pk_bits};
                b.last_byte = 1'b1;
                pred_q.push_back(b);
                pk_bits = '0;
                pk_cnt  = '0;
            end
            return;
        end
        w = (it.field_width > MAX_W) ? MAX_W : it.field_width;
        if (w == 0)
            return;
        acc    = {33'd0, pk_bits}
               | (({8'd0, it.field_value} & ((40'd1 << w) - 40'd1)) << pk_cnt);
        total  = pk_cnt + w;
        nbytes = total / 8;
        for (int i = 0; i < nbytes; i++)
        begin
            b.out_byte  = acc[8*i +: 8];
            b.last_byte = (i == nbytes - 1);
            pred_q.push_back(b);
        end
        pk_cnt  = 3'(total);
        pk_bits = 7'(acc >> (8 * nbytes)) & ~(7'h7F << pk_cnt);
    endfunction

    function automatic item_t rand_item();
        item_t       it;
        int unsigned r;
        r = $urandom_range(99);
        it.field_value = $urandom();
        if (r < 12)
        begin
            it.cmd         = CMD_ALIGN;
            it.field_width = WIDTH_W'($urandom());
        end
        else
        begin
            it.cmd = CMD_APPEND;
            if (r < 18)
                it.field_width = '0;
            else if (r < 26)
                it.field_width = WIDTH_W'($urandom_range(63, 33));
            else
                it.field_width = WIDTH_W'($urandom_range(MAX_W, 1));
        end
        return it;
    endfunction

    // Offer one item and hold it until the transfer happens. The owed bytes go
    // into want_bytes: from the table if the row has them, otherwise from the
    // model. The model runs on every item so its state keeps up.
    task automatic send_item(input item_t it, input logic [2:0] n_typed,
                             input logic [31:0] typed);
        result_t b;
        if (tx_gaps)
        begin
            while ($urandom_range(99) < 18)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);

        pack_item(it);
        if (n_typed != PRED)
        begin
            for (int i = 0; i < n_typed; i++)
            begin
                b.out_byte  = typed[8*i +: 8];
                b.last_byte = (i == n_typed - 1);
                want_bytes.push_back(b);
            end
        end
        else
        begin
            foreach (pred_q[i])
                want_bytes.push_back(pred_q[i]);
        end

        n_items++;
        if (it.cmd == CMD_ALIGN)
            n_aligns++;
        else if (it.field_width == 0)
            n_zero_w++;
        else if (it.field_width > MAX_W)
            n_big_w++;
    endtask

    // Drop valid and wait until every owed byte is out. Then let the block
    // settle a while longer so that any extra byte shows up as an error.
    task automatic wait_drain();
        int unsigned guard;
        guard = 0;
        item_valid <= 1'b0;
        while (want_bytes.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver. Normally it stalls in about 18% of cycles. RX_FREE never
    // stalls. RX_HOLD stalls for one long stretch so that the block backs up
    // and stalls its own input, then returns to random.
    initial
    begin
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_mode == RX_HOLD)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_mode = RX_RANDOM;
                result_stall <= 1'b0;
            end
            else if (rx_mode == RX_FREE)
                result_stall <= 1'b0;
            else
                result_stall <= ($urandom_range(99) < 18);
        end
    end

    // Byte checker: every result transfer must match the oldest owed byte.
    always @(posedge clk)
    begin : chk
        result_t want;
        if (rst_n)
        begin
            if (item_valid && item_stall)
                n_in_stalls++;
            if (result_valid && !result_stall)
            begin
                if (want_bytes.size() == 0)
                begin
                    $error("unexpected byte: out_byte=%h last_byte=%b",
                           result.out_byte, result.last_byte);
                    n_errors++;
                end
                else
                begin
                    want = want_bytes.pop_front();
                    n_bytes++;
                    if (result.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h",
                               want.out_byte, result.out_byte);
                        n_errors++;
                    end
                    if (result.last_byte !== want.last_byte)
                    begin
                        $error("last_byte: expected %b, got %b",
                               want.last_byte, result.last_byte);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        n_errors    = 0;
        n_items     = 0;
        n_aligns    = 0;
        n_zero_w    = 0;
        n_big_w     = 0;
        n_bytes     = 0;
        n_in_stalls = 0;
        pk_bits     = '0;
        pk_cnt      = '0;
        tx_gaps     = 1'b1;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (DIR_ROWS[i])
            send_item(DIR_ROWS[i].it, DIR_ROWS[i].n_typed, DIR_ROWS[i].bytes);

        // Random traffic, with gaps on both sides
        repeat (RAND_ITEMS_A)
            send_item(rand_item(), PRED, '0);

        // Back pressure: the receiver holds off while the sender keeps offering
        // full 32-bit fields, so the result side fills up and the block stalls
        // its input. Then the sender pauses until every owed byte is out.
        tx_gaps = 1'b0;
        rx_mode = RX_HOLD;
        for (int i = 0; i < HOLD_ITEMS; i++)
            send_item('{CMD_APPEND, 32'($urandom()), 6'd32}, PRED, '0);
        wait_drain();

        // A long stretch at full rate: no gaps on either side
        rx_mode = RX_FREE;
        repeat (RAND_ITEMS_B)
            send_item(rand_item(), PRED, '0);

        // Back to random gaps. A trailing align flushes what is still pending.
        rx_mode = RX_RANDOM;
        tx_gaps = 1'b1;
        repeat (RAND_ITEMS_C)
            send_item(rand_item(), PRED, '0);
        send_item('{CMD_ALIGN, 32'($urandom()), 6'd0}, PRED, '0);
        wait_drain();

        if (want_bytes.size() != 0)
        begin
            $error("%0d bytes never came out", want_bytes.size());
            n_errors++;
        end

        $display("run: %0d items (%0d align, %0d zero width, %0d over-wide), %0d bytes checked",
                 n_items, n_aligns, n_zero_w, n_big_w, n_bytes);
        $display("run: %0d cycles of input back pressure, %0d mismatches",
                 n_in_stalls, n_errors);
        if (n_errors == 0)
            $display("tb_lsb_first_bit_packer: PASS");
        else
            $display("tb_lsb_first_bit_packer: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_lsb_first_bit_packer: FAIL");
        $finish;
    end

endmodule
